@@ rtl/gle_pkg.sv @@
`timescale 1ns / 1ps
// Shared types and constants for the GIF LZW encoder.
// No dependencies; every other file of the block depends on this package.

package gle_pkg;

    localparam int CODE_BITS     = 12;
    localparam int SYM_BITS      = 8;
    localparam int WIDTH_BITS    = 4;
    localparam int CHUNK_BITS    = 8;
    localparam int CFG_IDX_BITS  = 2;
    localparam int CFG_DATA_BITS = 9;

    localparam logic [CFG_IDX_BITS-1:0] CFG_MIN_CODE_BITS     = 2'd0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_REMAP_ENABLE      = 2'd1;
    localparam logic [CFG_IDX_BITS-1:0] CFG_TRANSPARENT_VALUE = 2'd2;

    localparam logic [WIDTH_BITS-1:0]    MIN_BITS_RESET    = 4'd8;
    localparam logic [CFG_DATA_BITS-1:0] TRANSPARENT_RESET = 9'd256;

    typedef struct packed {
        logic [SYM_BITS-1:0] pixel_index;
        logic                frame_last;
    } pix_item_t;

    typedef struct packed {
        logic [7:0]            data_byte;
        logic                  chunk_end;
        logic [CHUNK_BITS-1:0] chunk_length;
        logic                  stream_last;
    } byte_item_t;

    typedef struct packed {
        logic [CODE_BITS-1:0]  code;
        logic [WIDTH_BITS-1:0] len;
        logic                  flush;
    } code_item_t;

endpackage

@@ rtl/gle_packer.sv @@
`timescale 1ns / 1ps
// Bit packer of the GIF LZW encoder: appends variable-width codes LSB-first
// and sends one byte per item with sub-block and end-of-stream marks.
// Depends on gle_pkg.

module gle_packer #(
    parameter int CHUNK_BYTES = 255
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   code_valid,
    input  gle_pkg::code_item_t    code_item,
    output logic                   code_take,
    output logic                   byte_valid,
    input  logic                   byte_stall,
    output gle_pkg::byte_item_t    byte_item
);
    import gle_pkg::*;

    localparam int ACC_BITS = CODE_BITS + 8;
    localparam int CNT_BITS = $clog2(ACC_BITS + 1);
    localparam logic [CNT_BITS-1:0]   BYTE_CNT    = CNT_BITS'(8);
    localparam logic [CHUNK_BITS-1:0] CHUNK_LIMIT = CHUNK_BITS'(CHUNK_BYTES);
    localparam logic [CODE_BITS-1:0]  CODE_ONES   = {CODE_BITS{1'b1}};

    logic [ACC_BITS-1:0]   acc_reg, acc_next, acc_after;
    logic [CNT_BITS-1:0]   cnt_reg, cnt_next, cnt_after;
    logic                  flush_reg, flush_next, flush_after;
    logic [CHUNK_BITS-1:0] chunk_cnt_reg, chunk_cnt_next, chunk_fill;
    logic                  byte_valid_reg, byte_valid_next;
    byte_item_t            byte_item_reg, byte_item_next;
    logic                  out_free, can_emit, emit, last_byte, chunk_close;
    logic [CODE_BITS-1:0]  code_bits;

    always_comb
    begin
        out_free    = !byte_valid_reg || !byte_stall;
        can_emit    = (cnt_reg >= BYTE_CNT) || (flush_reg && (cnt_reg != '0));
        emit        = out_free && can_emit;
        last_byte   = flush_reg && (cnt_reg <= BYTE_CNT);
        cnt_after   = emit ? (last_byte ? '0 : cnt_reg - BYTE_CNT) : cnt_reg;
        acc_after   = emit ? (acc_reg >> 8) : acc_reg;
        flush_after = flush_reg && !(emit && last_byte);

        code_take = code_valid && !flush_after && (cnt_after < BYTE_CNT);
        code_bits = code_item.code & ~(CODE_ONES << code_item.len);

        if (code_take)
        begin
            acc_next   = acc_after | (ACC_BITS'(code_bits) << cnt_after[2:0]);
            cnt_next   = cnt_after + CNT_BITS'(code_item.len);
            flush_next = code_item.flush;
        end
        else
        begin
            acc_next   = acc_after;
            cnt_next   = cnt_after;
            flush_next = flush_after;
        end

        chunk_fill  = chunk_cnt_reg + 1'b1;
        chunk_close = last_byte || (chunk_fill >= CHUNK_LIMIT);
        if (emit)
        begin
            chunk_cnt_next = chunk_close ? '0 : chunk_fill;
        end
        else
        begin
            chunk_cnt_next = chunk_cnt_reg;
        end

        byte_item_next.data_byte    = acc_reg[7:0];
        byte_item_next.chunk_end    = chunk_close;
        byte_item_next.chunk_length = chunk_close ? chunk_fill : '0;
        byte_item_next.stream_last  = last_byte;

        if (emit)
        begin
            byte_valid_next = 1'b1;
        end
        else if (out_free)
        begin
            byte_valid_next = 1'b0;
        end
        else
        begin
            byte_valid_next = byte_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg        <= '0;
            cnt_reg        <= '0;
            flush_reg      <= 1'b0;
            chunk_cnt_reg  <= '0;
            byte_valid_reg <= 1'b0;
        end
        else
        begin
            acc_reg        <= acc_next;
            cnt_reg        <= cnt_next;
            flush_reg      <= flush_next;
            chunk_cnt_reg  <= chunk_cnt_next;
            byte_valid_reg <= byte_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            byte_item_reg <= byte_item_next;
        end
    end

    assign byte_valid = byte_valid_reg;
    assign byte_item  = byte_item_reg;

endmodule

@@ rtl/gif_lzw_encoder.sv @@
`timescale 1ns / 1ps
// Top level of the GIF LZW encoder: dictionary memories, lookup pipeline and
// code sequencing. Depends on gle_pkg and gle_packer.
//
// Usage: pixels of one frame enter on the pix channel in scan order, with
// frame_last set on the final pixel. Packed code bytes leave on the byte
// channel, one per item, with chunk_end and chunk_length closing each
// sub-block and stream_last on the final byte of the frame. The user must
// write registers on the cfg channel (always ready) only while the block is
// idle; the block itself does not enforce this. Each pixel passes through a
// dictionary read, then a read of the code owner memory that confirms the
// entry belongs to the current table, and the decision that forms the next
// pixel's dictionary address. The byte path sends at most one byte per
// cycle; a pixel that emits codes (a miss, frame start, table full, frame
// end) holds the next decision until its codes have entered the packer.
// Reset clears the control state; the memories need no clearing, since an
// entry counts only when its code lies in the live code range and the owner
// memory names its prefix and symbol. A stalled byte holds the output
// register, and the pixel side stalls once the code list and packer fill.

module gif_lzw_encoder #(
    parameter int MAX_CODES   = 4096,
    parameter int CHUNK_BYTES = 255
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  pix_valid,
    output logic                                  pix_stall,
    input  gle_pkg::pix_item_t                    pix_item,
    output logic                                  byte_valid,
    input  logic                                  byte_stall,
    output gle_pkg::byte_item_t                   byte_item,
    input  logic                                  cfg_valid,
    output logic                                  cfg_ready,
    input  logic [gle_pkg::CFG_IDX_BITS-1:0]      cfg_index,
    input  logic [gle_pkg::CFG_DATA_BITS-1:0]     cfg_data
);
    import gle_pkg::*;

    localparam int ADDR_BITS  = $clog2(MAX_CODES);
    localparam int DICT_BITS  = ADDR_BITS + SYM_BITS;
    localparam int DICT_DEPTH = MAX_CODES * (2 ** SYM_BITS);
    localparam int CMP_BITS   = CODE_BITS + 1;
    localparam int SLOTS      = 6;
    localparam int SLOT_BITS  = $clog2(SLOTS);
    localparam int SLOT_START = 0;
    localparam int SLOT_MISS  = 1;
    localparam int SLOT_FULL  = 2;
    localparam int SLOT_LAST  = 3;
    localparam int SLOT_CLEAR = 4;
    localparam int SLOT_END   = 5;
    localparam logic [CODE_BITS-1:0] TOP_CODE = CODE_BITS'(MAX_CODES - 1);

    typedef enum logic [1:0] {
        S_IDLE,
        S_LOOKUP,
        S_DECIDE
    } phase_t;

    logic [CODE_BITS-1:0] dict_mem [DICT_DEPTH];
    logic [DICT_BITS-1:0] owner_mem [MAX_CODES];
    logic [CODE_BITS-1:0] dict_q_reg;
    logic [DICT_BITS-1:0] owner_q_reg;

    logic [WIDTH_BITS-1:0]    min_bits_reg;
    logic                     remap_reg;
    logic [CFG_DATA_BITS-1:0] transp_reg;

    phase_t               phase_reg, phase_next;
    logic                 item_valid_reg, item_valid_next;
    pix_item_t            item_reg;
    logic [SYM_BITS-1:0]  sym_reg;
    logic                 last_reg;
    logic [CODE_BITS-1:0] found_reg;
    logic                 fwd_reg, fwd_next;
    logic [CODE_BITS-1:0] fwd_code_reg;

    logic                  frame_open_reg, frame_open_next;
    logic                  prefix_valid_reg, prefix_valid_next;
    logic [CODE_BITS-1:0]  prefix_reg, prefix_next;
    logic [CODE_BITS-1:0]  highest_reg, highest_next;
    logic [CODE_BITS-1:0]  base_reg, base_next;
    logic [WIDTH_BITS-1:0] width_reg, width_next;

    code_item_t           list_reg [SLOTS];
    code_item_t           list_new [SLOTS];
    logic [SLOTS-1:0]     mask_reg, mask_next, mask_new;
    logic [SLOT_BITS-1:0] pick;
    logic                 code_valid, code_take;
    code_item_t           code_item;

    logic [WIDTH_BITS-1:0] eff_bits, first_width, w0, w1, w_post;
    logic [CFG_DATA_BITS-1:0] clear_val;
    logic [CODE_BITS-1:0] clear_code, end_code, first_high, first_base;
    logic [CODE_BITS-1:0] h0, h1, h_post, b0, b_post, p1, found;
    logic [SYM_BITS-1:0]  sym_issue;
    logic [DICT_BITS-1:0] lookup_key, dict_raddr;
    logic                 open_now, pv, hit, miss, full;
    logic                 issue, decide_fire, dict_we;

    // Register values and mapping of the incoming pixel.
    always_comb
    begin
        if (min_bits_reg == '0)
        begin
            eff_bits = 4'd1;
        end
        else if (min_bits_reg > 4'd8)
        begin
            eff_bits = 4'd8;
        end
        else
        begin
            eff_bits = min_bits_reg;
        end
        clear_val   = 9'd1 << eff_bits;
        clear_code  = CODE_BITS'(clear_val);
        end_code    = clear_code + 1'b1;
        first_width = eff_bits + 4'd1;
        first_high  = clear_code + 12'd1;
        first_base  = clear_code + 12'd2;

        if (remap_reg)
        begin
            if ({1'b0, item_reg.pixel_index} == transp_reg)
            begin
                sym_issue = '0;
            end
            else
            begin
                sym_issue = item_reg.pixel_index + 8'd1;
            end
        end
        else
        begin
            sym_issue = item_reg.pixel_index;
        end
    end

    // Decision for the pixel in the decide step.
    always_comb
    begin
        open_now   = frame_open_reg;
        h0         = open_now ? highest_reg : first_high;
        w0         = open_now ? width_reg : first_width;
        b0         = open_now ? base_reg : first_base;
        pv         = open_now && prefix_valid_reg;
        lookup_key = {prefix_reg[ADDR_BITS-1:0], sym_reg};
        hit        = pv && (found_reg >= b0) && (found_reg <= h0) && (owner_q_reg == lookup_key);
        miss       = pv && !hit;
        h1         = miss ? h0 + 12'd1 : h0;
        if (miss && ({1'b0, h1} >= (CMP_BITS'(1) << w0)))
        begin
            w1 = w0 + 4'd1;
        end
        else
        begin
            w1 = w0;
        end
        full   = miss && (h1 >= TOP_CODE);
        h_post = full ? first_high : h1;
        w_post = full ? first_width : w1;
        b_post = full ? first_base : b0;
        p1     = hit ? found_reg : CODE_BITS'(sym_reg);

        for (int i = 0; i < SLOTS; i++)
        begin
            list_new[i].code  = clear_code;
            list_new[i].len   = w_post;
            list_new[i].flush = 1'b0;
        end
        list_new[SLOT_START].len  = first_width;
        list_new[SLOT_MISS].code  = prefix_reg;
        list_new[SLOT_MISS].len   = w0;
        list_new[SLOT_FULL].len   = w1;
        list_new[SLOT_LAST].code  = p1;
        list_new[SLOT_END].code   = end_code;
        list_new[SLOT_END].len    = first_width;
        list_new[SLOT_END].flush  = 1'b1;

        mask_new             = '0;
        mask_new[SLOT_START] = !open_now;
        mask_new[SLOT_MISS]  = miss;
        mask_new[SLOT_FULL]  = full;
        mask_new[SLOT_LAST]  = last_reg;
        mask_new[SLOT_CLEAR] = last_reg;
        mask_new[SLOT_END]   = last_reg;

        if (last_reg)
        begin
            frame_open_next   = 1'b0;
            prefix_valid_next = 1'b0;
            prefix_next       = '0;
            highest_next      = first_high;
            width_next        = first_width;
            base_next         = first_base;
        end
        else
        begin
            frame_open_next   = 1'b1;
            prefix_valid_next = 1'b1;
            prefix_next       = p1;
            highest_next      = h_post;
            width_next        = w_post;
            base_next         = b_post;
        end
    end

    // Pipeline control and code list hand-off.
    always_comb
    begin
        decide_fire = (phase_reg == S_DECIDE) && (mask_reg == '0);
        issue       = item_valid_reg && ((phase_reg == S_IDLE) || decide_fire);
        pix_stall   = item_valid_reg && !issue;
        dict_we     = decide_fire && miss;
        dict_raddr  = {(decide_fire ? prefix_next[ADDR_BITS-1:0]
                                    : prefix_reg[ADDR_BITS-1:0]), sym_issue};
        fwd_next    = issue && dict_we && (dict_raddr == lookup_key);
        found       = fwd_reg ? fwd_code_reg : dict_q_reg;

        if (pix_valid && !pix_stall)
        begin
            item_valid_next = 1'b1;
        end
        else if (issue)
        begin
            item_valid_next = 1'b0;
        end
        else
        begin
            item_valid_next = item_valid_reg;
        end

        case (phase_reg)
            S_IDLE:
            begin
                phase_next = issue ? S_LOOKUP : S_IDLE;
            end
            S_LOOKUP:
            begin
                phase_next = S_DECIDE;
            end
            S_DECIDE:
            begin
                if (decide_fire)
                begin
                    phase_next = issue ? S_LOOKUP : S_IDLE;
                end
                else
                begin
                    phase_next = S_DECIDE;
                end
            end
            default:
            begin
                phase_next = S_IDLE;
            end
        endcase

        pick = '0;
        for (int i = SLOTS - 1; i >= 0; i--)
        begin
            if (mask_reg[i])
            begin
                pick = SLOT_BITS'(i);
            end
        end
        code_valid = |mask_reg;
        code_item  = list_reg[pick];

        mask_next = mask_reg;
        if (decide_fire)
        begin
            mask_next = mask_new;
        end
        else if (code_take)
        begin
            mask_next[pick] = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_bits_reg     <= MIN_BITS_RESET;
            remap_reg        <= 1'b0;
            transp_reg       <= TRANSPARENT_RESET;
            phase_reg        <= S_IDLE;
            item_valid_reg   <= 1'b0;
            fwd_reg          <= 1'b0;
            frame_open_reg   <= 1'b0;
            prefix_valid_reg <= 1'b0;
            prefix_reg       <= '0;
            highest_reg      <= 12'd257;
            base_reg         <= 12'd258;
            width_reg        <= 4'd9;
            mask_reg         <= '0;
        end
        else
        begin
            if (cfg_valid)
            begin
                case (cfg_index)
                    CFG_MIN_CODE_BITS:     min_bits_reg <= cfg_data[WIDTH_BITS-1:0];
                    CFG_REMAP_ENABLE:      remap_reg    <= cfg_data[0];
                    CFG_TRANSPARENT_VALUE: transp_reg   <= cfg_data;
                    default:               ;
                endcase
            end
            phase_reg      <= phase_next;
            item_valid_reg <= item_valid_next;
            fwd_reg        <= fwd_next;
            mask_reg       <= mask_next;
            if (decide_fire)
            begin
                frame_open_reg   <= frame_open_next;
                prefix_valid_reg <= prefix_valid_next;
                prefix_reg       <= prefix_next;
                highest_reg      <= highest_next;
                base_reg         <= base_next;
                width_reg        <= width_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (pix_valid && !pix_stall)
        begin
            item_reg <= pix_item;
        end
        if (issue)
        begin
            sym_reg  <= sym_issue;
            last_reg <= item_reg.frame_last;
        end
        if (fwd_next)
        begin
            fwd_code_reg <= h1;
        end
        if (phase_reg == S_LOOKUP)
        begin
            found_reg <= found;
        end
        if (decide_fire)
        begin
            for (int i = 0; i < SLOTS; i++)
            begin
                list_reg[i] <= list_new[i];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (dict_we)
        begin
            dict_mem[lookup_key] <= h1;
        end
        if (issue)
        begin
            dict_q_reg <= dict_mem[dict_raddr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (dict_we)
        begin
            owner_mem[h1[ADDR_BITS-1:0]] <= lookup_key;
        end
        if (phase_reg == S_LOOKUP)
        begin
            owner_q_reg <= owner_mem[found[ADDR_BITS-1:0]];
        end
    end

    assign cfg_ready = 1'b1;

    gle_packer #(
        .CHUNK_BYTES (CHUNK_BYTES)
    ) u_packer (
        .clk        (clk),
        .rst_n      (rst_n),
        .code_valid (code_valid),
        .code_item  (code_item),
        .code_take  (code_take),
        .byte_valid (byte_valid),
        .byte_stall (byte_stall),
        .byte_item  (byte_item)
    );

endmodule

@@ rtl/gle_checker.sv @@
`timescale 1ns / 1ps
// Port checker of the GIF LZW encoder byte channel, with its bind statement.
// Depends on gle_pkg and the gif_lzw_encoder top level.

module gle_checker (
    input logic                clk,
    input logic                rst_n,
    input logic                byte_valid,
    input logic                byte_stall,
    input gle_pkg::byte_item_t byte_item
);

    property p_stall_holds;
        @(posedge clk) disable iff (!rst_n)
        byte_valid && byte_stall |=> byte_valid && $stable(byte_item);
    endproperty

    property p_length_only_on_end;
        @(posedge clk) disable iff (!rst_n)
        byte_valid && !byte_item.chunk_end |-> byte_item.chunk_length == 8'd0;
    endproperty

    property p_end_has_length;
        @(posedge clk) disable iff (!rst_n)
        byte_valid && byte_item.chunk_end |-> byte_item.chunk_length != 8'd0;
    endproperty

    property p_last_closes_chunk;
        @(posedge clk) disable iff (!rst_n)
        byte_valid && byte_item.stream_last |-> byte_item.chunk_end;
    endproperty

    a_stall_holds: assert property (p_stall_holds)
        else $error("Byte item changed while stalled.");
    a_length_only_on_end: assert property (p_length_only_on_end)
        else $error("Chunk length set on a byte that does not close a sub-block.");
    a_end_has_length: assert property (p_end_has_length)
        else $error("Sub-block closed with zero length.");
    a_last_closes_chunk: assert property (p_last_closes_chunk)
        else $error("Final byte does not close its sub-block.");

endmodule

bind gif_lzw_encoder gle_checker u_gle_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .byte_valid (byte_valid),
    .byte_stall (byte_stall),
    .byte_item  (byte_item)
);
